>>> rtl/core/matrix_vector_multiply_assert.svh
// ----------------------------------------------------------------------------
// matrix vector multiply assertion macros
// shared property wrappers for the checks at the end of mvm_back
// ----------------------------------------------------------------------------
`ifndef MATRIX_VECTOR_MULTIPLY_ASSERT_SVH
`define MATRIX_VECTOR_MULTIPLY_ASSERT_SVH

// same-cycle implication, off while in reset
`define MVM_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("matrix vector multiply: same-cycle check failed");

// next-cycle implication, off while in reset
`define MVM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("matrix vector multiply: next-cycle check failed");

`endif

>>> rtl/core/mvm_pkg.sv
// ----------------------------------------------------------------------------
// mvm_pkg
// shared types and constants of the matrix vector multiply block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mvm_pkg;

  // built matrix dimension unless overridden at the top level
  localparam int N_MAX_DEFAULT = 16;

  // fixed field widths
  localparam int IDX_W   = 4;
  localparam int VAL_W   = 16;
  localparam int ACC_W   = 40;
  localparam int PROD_W  = 32;
  localparam int CFG_W   = 5;
  localparam logic [CFG_W-1:0] VEC_LEN_RESET = 5'd16;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // input kinds
  localparam logic OP_MATRIX = 1'b0;
  localparam logic OP_VECTOR = 1'b1;

  // one classified item as it waits in the queue
  typedef struct packed {
    logic                    op;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    logic                    trig;
  } mvm_cmd_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MAC,
    BK_WAIT
  } mvm_state_t;

endpackage

>>> rtl/core/mvm_front.sv
// ----------------------------------------------------------------------------
// mvm_front
// accepts input items, holds the length register and classifies each item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mvm_front #(
  parameter int N_MAX = mvm_pkg::N_MAX_DEFAULT,
  localparam int LW = $clog2(N_MAX + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [mvm_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [23:0]                s_axis_tdata,  // row[3:0], col[7:4], value[23:8]
  input  logic                       s_axis_tuser,  // op
  output logic [LW-1:0]              len,
  input  logic                       q_full,
  output logic                       q_push,
  output mvm_pkg::mvm_cmd_t          q_cmd
);

  logic [mvm_pkg::CFG_W-1:0] vec_len;
  logic                      in_range;

  // length register
  always_ff @(posedge clk) begin
    if (rst) begin
      vec_len <= mvm_pkg::VEC_LEN_RESET;
    end else if (cfg_we) begin
      vec_len <= cfg_wdata;
    end
  end

  // clamp the length into 1..N_MAX
  always_comb begin
    priority if (vec_len == '0) begin
      len = LW'(1);
    end else if (32'(vec_len) > N_MAX) begin
      len = LW'(N_MAX);
    end else begin
      len = LW'(vec_len);
    end
  end

  // split fields and classify
  always_comb begin
    q_cmd.op    = s_axis_tuser;
    q_cmd.row   = s_axis_tdata[3:0];
    q_cmd.col   = s_axis_tdata[7:4];
    q_cmd.value = s_axis_tdata[23:8];
    q_cmd.trig  = (s_axis_tuser == mvm_pkg::OP_VECTOR) &&
                  (32'(q_cmd.col) == 32'(len) - 32'd1);
    in_range    = (32'(q_cmd.col) < N_MAX) &&
                  ((s_axis_tuser == mvm_pkg::OP_VECTOR) || (32'(q_cmd.row) < N_MAX));
  end

  // out-of-range items are taken and dropped
  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && !q_full && in_range;

endmodule

>>> rtl/core/mvm_queue.sv
// ----------------------------------------------------------------------------
// mvm_queue
// short command queue between the front and the back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mvm_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mvm_pkg::mvm_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output mvm_pkg::mvm_cmd_t pop_cmd,
  output logic              empty
);

  localparam int PW = $clog2(mvm_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(mvm_pkg::QUEUE_DEPTH + 1);

  mvm_pkg::mvm_cmd_t slots [mvm_pkg::QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CW-1:0]     count;

  assign full    = (count == CW'(mvm_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == mvm_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == mvm_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/core/mvm_back.sv
// ----------------------------------------------------------------------------
// mvm_back
// executes queued items: store writes and the row by row multiply-accumulate
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "matrix_vector_multiply_assert.svh"

module mvm_back #(
  parameter int N_MAX = mvm_pkg::N_MAX_DEFAULT,
  localparam int LW = $clog2(N_MAX + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [LW-1:0]     len,
  input  logic              q_empty,
  input  mvm_pkg::mvm_cmd_t q_cmd,
  output logic              q_pop,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [47:0]       m_axis_tdata,  // out_row[3:0], out_value[43:4], zero[47:44]
  output logic              m_axis_tlast   // last
);

  localparam int IW    = (N_MAX > 1) ? $clog2(N_MAX) : 1;
  localparam int DEPTH = N_MAX * N_MAX;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  mvm_pkg::mvm_state_t state, state_next;

  logic signed [mvm_pkg::VAL_W-1:0]  mat_mem [DEPTH];
  logic signed [mvm_pkg::VAL_W-1:0]  vec_mem [N_MAX];
  logic signed [mvm_pkg::VAL_W-1:0]  mat_q;
  logic signed [mvm_pkg::VAL_W-1:0]  vec_q;
  logic signed [mvm_pkg::PROD_W-1:0] prod;
  logic signed [mvm_pkg::ACC_W-1:0]  acc;
  logic signed [mvm_pkg::ACC_W-1:0]  out_value;
  logic [mvm_pkg::IDX_W-1:0]         out_row;
  logic                              out_valid;
  logic                              out_last;

  logic [IW-1:0] r;
  logic [IW-1:0] c;
  logic          s1_v, s1_last, s2_v, s2_last, done_q;
  logic          col_last, row_last;
  logic          issue, out_load, start_run, next_row;
  logic [AW-1:0] wr_addr, rd_addr;

  assign col_last = (32'(c) == 32'(len) - 32'd1);
  assign row_last = (32'(r) == 32'(len) - 32'd1);
  assign wr_addr  = AW'(q_cmd.row) * AW'(N_MAX) + AW'(q_cmd.col);
  assign rd_addr  = AW'(r) * AW'(N_MAX) + AW'(c);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mvm_pkg::BK_IDLE: begin
        if (!q_empty && q_cmd.trig) state_next = mvm_pkg::BK_MAC;
      end
      mvm_pkg::BK_MAC: begin
        if (col_last) state_next = mvm_pkg::BK_WAIT;
      end
      mvm_pkg::BK_WAIT: begin
        if (out_load) state_next = row_last ? mvm_pkg::BK_IDLE : mvm_pkg::BK_MAC;
      end
      default: state_next = mvm_pkg::BK_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    q_pop    = (state == mvm_pkg::BK_IDLE) && !q_empty;
    issue    = (state == mvm_pkg::BK_MAC);
    out_load = (state == mvm_pkg::BK_WAIT) && done_q && (!out_valid || m_axis_tready);
    start_run = q_pop && q_cmd.trig;
    next_row  = out_load && !row_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mvm_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // matrix store, up to one write and one read a cycle
  always_ff @(posedge clk) begin
    if (q_pop && (q_cmd.op == mvm_pkg::OP_MATRIX)) begin
      mat_mem[wr_addr] <= q_cmd.value;
    end
    mat_q <= mat_mem[rd_addr];
  end

  // vector store
  always_ff @(posedge clk) begin
    if (q_pop && (q_cmd.op == mvm_pkg::OP_VECTOR)) begin
      vec_mem[IW'(q_cmd.col)] <= q_cmd.value;
    end
    vec_q <= vec_mem[c];
  end

  // row and column counters
  always_ff @(posedge clk) begin
    if (rst) begin
      r <= '0;
      c <= '0;
    end else begin
      if (start_run) begin
        r <= '0;
        c <= '0;
      end else begin
        if (issue) c <= col_last ? '0 : c + IW'(1);
        if (next_row) r <= r + IW'(1);
      end
    end
  end

  // read, multiply and accumulate pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v    <= 1'b0;
      s1_last <= 1'b0;
      s2_v    <= 1'b0;
      s2_last <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      s1_v    <= issue;
      s1_last <= issue && col_last;
      s2_v    <= s1_v;
      s2_last <= s1_last;
      if (s2_v && s2_last) begin
        done_q <= 1'b1;
      end else if (out_load) begin
        done_q <= 1'b0;
      end
    end
  end

  // product and running sum
  always_ff @(posedge clk) begin
    prod <= mat_q * vec_q;
    if (start_run || next_row) begin
      acc <= '0;
    end else if (s2_v) begin
      acc <= acc + mvm_pkg::ACC_W'(prod);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row   <= mvm_pkg::IDX_W'(r);
      out_value <= acc;
      out_last  <= row_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_value, out_row};
  assign m_axis_tlast  = out_last;

  // checks
  `MVM_ASSERT_SAME(a_done_only_waiting, clk, rst, done_q, state == mvm_pkg::BK_WAIT)
  `MVM_ASSERT_SAME(a_idle_pipe_empty, clk, rst, state == mvm_pkg::BK_IDLE, !s1_v && !s2_v && !done_q)
  `MVM_ASSERT_NEXT(a_last_row_ends_run, clk, rst, out_load && row_last, (state == mvm_pkg::BK_IDLE) && m_axis_tvalid && m_axis_tlast)

endmodule

>>> rtl/core/matrix_vector_multiply.sv
// a store write lands once its item has passed the queue and been popped by the
// back end while idle; a run ends with len results
// throughput: one item a cycle for writes while the queue has room and the back end is idle;
// a run holds the back end, one multiply-accumulate a cycle while in the MAC state
// reset: rst is synchronous; queue, sequencer and output are cleared, vec_len is 16,
// matrix and vector stores are not cleared and need writing before use
// ----------------------------------------------------------------------------
// matrix_vector_multiply
// square fixed point matrix times vector with stored matrix and vector
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix_vector_multiply #(
  parameter int N_MAX = mvm_pkg::N_MAX_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [mvm_pkg::CFG_W-1:0] cfg_wdata,      // vec_len
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [23:0]               s_axis_tdata,   // row[3:0], col[7:4], value[23:8]
  input  logic                      s_axis_tuser,   // op
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [47:0]               m_axis_tdata,   // out_row[3:0], out_value[43:4], zero
  output logic                      m_axis_tlast    // last
);

  localparam int LW = $clog2(N_MAX + 1);

  logic [LW-1:0]     len;
  logic              q_push, q_full, q_pop, q_empty;
  mvm_pkg::mvm_cmd_t push_cmd, pop_cmd;

  // intake and classification
  mvm_front #(.N_MAX(N_MAX)) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .len           (len),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (push_cmd)
  );

  // decoupling queue
  mvm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  // execution
  mvm_back #(.N_MAX(N_MAX)) u_back (
    .clk           (clk),
    .rst           (rst),
    .len           (len),
    .q_empty       (q_empty),
    .q_cmd         (pop_cmd),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for matrix_vector_multiply. Matrix entries and vector
// elements are streamed in, and each closing vector element predicts one dot
// product per row. Every returned item is compared field by field with the
// oldest prediction. Both stream sides idle at random but for one stretch of
// phases, and the vector length is changed between phases while the block is
// quiet. Lengths of zero and above the built size are included.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int NB           = 16;         // built matrix dimension
  localparam int IDLE_PCT     = 27;
  localparam int QUIET_CYCLES = 24;         // queue drain plus store write
  localparam int LIMIT_CYCLES = 1_500_000;
  localparam int RANDOM_ITEMS = 150;

  localparam int IDX_W = mvm_pkg::IDX_W;
  localparam int VAL_W = mvm_pkg::VAL_W;
  localparam int ACC_W = mvm_pkg::ACC_W;
  localparam int CFG_W = mvm_pkg::CFG_W;

  // one predicted row result
  typedef struct {
    logic [IDX_W-1:0]        row;
    logic signed [ACC_W-1:0] value;
    logic                    last;
  } dot_result_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_W-1:0]          cfg_wdata;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [23:0]               s_axis_tdata;   // row[3:0], col[7:4], value[23:8]
  logic                      s_axis_tuser;   // op
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic [47:0]               m_axis_tdata;   // out_row[3:0], out_value[43:4], zero
  logic                      m_axis_tlast;   // last

  // predictor state
  logic signed [VAL_W-1:0] mat_store [NB][NB];
  logic signed [VAL_W-1:0] vec_store [NB];
  bit                      mat_set   [NB][NB];
  bit                      vec_set   [NB];
  logic [CFG_W-1:0]        vec_len_reg;
  dot_result_t             dot_products_q [$];

  int errors;
  int items_sent;
  int results_checked;
  int runs_started;
  int cycle_count;
  int idle_pct;

  matrix_vector_multiply i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_top: errors");
      $finish;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= idle_pct);
  end

  // effective length: zero acts as one, above the built size as the built size
  function automatic int clamp_len(logic [CFG_W-1:0] v);
    if (v < 1) return 1;
    if (v > NB) return NB;
    return int'(v);
  endfunction

  // true when a run of n reads only written entries
  function automatic bit run_is_sound(int n, int new_col);
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++)
        if (!mat_set[r][c]) return 1'b0;
    for (int c = 0; c < n; c++)
      if (!vec_set[c] && c != new_col) return 1'b0;
    return 1'b1;
  endfunction

  // q1.15 value with the extremes picked often
  function automatic logic signed [VAL_W-1:0] pick_q15();
    int p;
    p = $urandom_range(7);
    if (p == 0) return -16'sd32768;
    if (p == 1) return 16'sd32767;
    return VAL_W'($urandom);
  endfunction

  // update the stores and queue the row dot products of a closing element
  task automatic absorb_item(logic op, logic [3:0] row, logic [3:0] col,
                             logic signed [VAL_W-1:0] value);
    int n;
    logic signed [ACC_W-1:0] acc;
    dot_result_t res;
    n = clamp_len(vec_len_reg);
    if (op == mvm_pkg::OP_MATRIX) begin
      mat_store[row][col] = value;
      mat_set[row][col]   = 1'b1;
    end else begin
      vec_store[col] = value;
      vec_set[col]   = 1'b1;
      if (int'(col) == n - 1) begin
        runs_started++;
        for (int r = 0; r < n; r++) begin
          acc = '0;
          for (int c = 0; c < n; c++)
            acc = acc + mat_store[r][c] * vec_store[c];
          res.row   = IDX_W'(r);
          res.value = acc;
          res.last  = (r == n - 1);
          dot_products_q.push_back(res);
        end
      end
    end
  endtask

  // send one item; a closing element that would read unwritten entries
  // becomes a matrix write instead
  task automatic send_item(logic op, logic [3:0] row, logic [3:0] col,
                           logic signed [VAL_W-1:0] value);
    int n;
    n = clamp_len(vec_len_reg);
    if (op == mvm_pkg::OP_VECTOR && int'(col) == n - 1 && !run_is_sound(n, int'(col)))
      op = mvm_pkg::OP_MATRIX;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {value, col, row};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    absorb_item(op, row, col, value);
  endtask

  // drop valid, wait for every result, then let the block settle
  task automatic wait_quiet();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (dot_products_q.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_vec_len(logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    vec_len_reg = v;
  endtask

  // result checker
  always @(posedge clk) begin
    dot_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (dot_products_q.size() == 0) begin
        $error("result item with nothing expected: out_row %0d", m_axis_tdata[3:0]);
        errors++;
      end else begin
        want = dot_products_q.pop_front();
        results_checked++;
        if (m_axis_tdata[3:0] !== want.row) begin
          $error("out_row expected %0d got %0d", want.row, m_axis_tdata[3:0]);
          errors++;
        end
        if ($signed(m_axis_tdata[43:4]) !== want.value) begin
          $error("out_value expected %0d got %0d", want.value,
                 $signed(m_axis_tdata[43:4]));
          errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last expected %0b got %0b", want.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // full size at the reset length: fill the whole matrix, two vector passes
  task automatic test_reset_length_full();
    logic signed [VAL_W-1:0] v;
    for (int r = 0; r < NB; r++)
      for (int c = 0; c < NB; c++) begin
        if (r == 0) v = -16'sd32768;
        else if (r == 1) v = 16'sd32767;
        else if (r == 2) v = (c % 2) ? 16'sd32767 : -16'sd32768;
        else v = pick_q15();
        send_item(mvm_pkg::OP_MATRIX, 4'(r), 4'(c), v);
      end
    for (int c = 0; c < NB; c++) send_item(mvm_pkg::OP_VECTOR, 4'd0, 4'(c), -16'sd32768);
    for (int c = 0; c < NB; c++) send_item(mvm_pkg::OP_VECTOR, 4'd15, 4'(c), 16'sd32767);
    wait_quiet();
  endtask

  // length one with extreme values, and a vector write past the length
  task automatic test_single_element();
    write_vec_len(5'd1);
    send_item(mvm_pkg::OP_MATRIX, 4'd0, 4'd0, -16'sd32768);
    send_item(mvm_pkg::OP_VECTOR, 4'd0, 4'd0, -16'sd32768);
    send_item(mvm_pkg::OP_MATRIX, 4'd0, 4'd0, 16'sd32767);
    send_item(mvm_pkg::OP_VECTOR, 4'd0, 4'd5, 16'sd1);
    send_item(mvm_pkg::OP_VECTOR, 4'd0, 4'd0, -16'sd32768);
    send_item(mvm_pkg::OP_VECTOR, 4'd0, 4'd0, 16'sd0);
    wait_quiet();
  endtask

  // lengths of zero and above the built size are clamped
  task automatic test_length_clamp();
    write_vec_len(5'd0);
    send_item(mvm_pkg::OP_VECTOR, 4'd0, 4'd0, 16'sd32767);
    wait_quiet();
    write_vec_len(5'd31);
    send_item(mvm_pkg::OP_VECTOR, 4'd0, 4'd15, -16'sd1);
    wait_quiet();
    write_vec_len(5'd17);
    send_item(mvm_pkg::OP_VECTOR, 4'd0, 4'd15, 16'sd2);
    wait_quiet();
  endtask

  // matrix write at the closing column yields nothing, old entries stay in use
  task automatic test_stale_entries();
    write_vec_len(5'd3);
    send_item(mvm_pkg::OP_MATRIX, 4'd2, 4'd2, 16'sd12345);
    send_item(mvm_pkg::OP_MATRIX, 4'd1, 4'd2, -16'sd4321);
    send_item(mvm_pkg::OP_VECTOR, 4'd0, 4'd2, 16'sd16384);
    send_item(mvm_pkg::OP_VECTOR, 4'd0, 4'd2, -16'sd16384);
    wait_quiet();
  endtask

  // random phases: mostly well-formed runs, some noise and broken sequences
  task automatic test_random();
    int start;
    int phase;
    int pick;
    int n;
    int nwr;
    logic [CFG_W-1:0] lenv;
    start = items_sent;
    phase = 0;
    while (items_sent - start < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 6) lenv = 5'd0;
      else if (pick < 12) lenv = CFG_W'($urandom_range(17, 31));
      else if (pick < 22) lenv = CFG_W'($urandom_range(6, 16));
      else lenv = CFG_W'($urandom_range(1, 5));
      wait_quiet();
      // a long stretch with no idling on either side
      idle_pct = (phase >= 8 && phase < 16) ? 0 : IDLE_PCT;
      write_vec_len(lenv);
      n = clamp_len(lenv);
      if ($urandom_range(5) == 0) begin
        repeat ($urandom_range(4, 12))
          send_item(1'($urandom), 4'($urandom), 4'($urandom), pick_q15());
      end else begin
        nwr = $urandom_range(0, (n < 4) ? n * n : 10);
        repeat (nwr) begin
          if ($urandom_range(4) == 0)
            send_item(mvm_pkg::OP_MATRIX, 4'($urandom), 4'($urandom), pick_q15());
          else
            send_item(mvm_pkg::OP_MATRIX, 4'($urandom_range(n - 1)),
                      4'($urandom_range(n - 1)), pick_q15());
        end
        for (int c = 0; c < n; c++) begin
          if ($urandom_range(7) == 0)
            send_item(mvm_pkg::OP_MATRIX, 4'($urandom), 4'($urandom), pick_q15());
          send_item(mvm_pkg::OP_VECTOR, 4'($urandom), 4'(c), pick_q15());
        end
        // a second run on the same data with a new closing element
        if ($urandom_range(2) == 0)
          send_item(mvm_pkg::OP_VECTOR, 4'($urandom), 4'(n - 1), pick_q15());
      end
      phase++;
    end
    idle_pct = IDLE_PCT;
  endtask

  initial begin
    errors          = 0;
    items_sent      = 0;
    results_checked = 0;
    runs_started    = 0;
    cycle_count     = 0;
    idle_pct        = IDLE_PCT;
    vec_len_reg     = mvm_pkg::VEC_LEN_RESET;
    for (int r = 0; r < NB; r++) begin
      vec_set[r] = 1'b0;
      for (int c = 0; c < NB; c++) mat_set[r][c] = 1'b0;
    end
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_length_full();
    test_single_element();
    test_length_clamp();
    test_stale_entries();
    test_random();
    wait_quiet();
    repeat (40) @(posedge clk);

    if (dot_products_q.size() != 0) begin
      $error("%0d expected results never arrived", dot_products_q.size());
      errors++;
    end
    $display("summary: %0d items sent, %0d runs, %0d row results compared",
             items_sent, runs_started, results_checked);
    $display("summary: lengths 0 to 31 incl. clamped ones, extremes, stale entries");
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
